// File: rtl/htfd_pkg.sv
package htfd_pkg;

  localparam logic [7:0] CRC_INIT = 8'hFF;
  localparam logic [7:0] CRC_POLY = 8'h31;

  localparam int TEMP_SCALE  = 17500;
  localparam int TEMP_OFFSET = 4500;
  localparam int HUM_SCALE   = 10000;
  localparam int HUM_MAX     = 10000;

  localparam int TEMP_W     = 15;
  localparam int HUM_W      = 14;
  localparam int TPROD_W    = 31;  // 17500 * 65535 < 2^31
  localparam int HPROD_W    = 30;  // 10000 * 65535 < 2^30
  localparam int TQ_W       = 15;  // quotient up to 17500
  localparam int HQ_W       = 15;  // quotient up to 10000

  // frame status bits
  localparam int STATUS_TEMP_BAD = 0;
  localparam int STATUS_HUM_BAD  = 1;
  localparam logic [1:0] STATUS_OK = 2'd0;

  // job queue between byte front end and conversion back end (power of two)
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [2:0] {
    POS_T_HI,
    POS_T_LO,
    POS_T_CRC,
    POS_H_HI,
    POS_H_LO,
    POS_H_CRC
  } pos_t;

  typedef struct packed {
    logic [15:0] temp_raw;
    logic [15:0] hum_raw;
    logic        temp_bad;
    logic        hum_bad;
  } job_t;

  // CRC-8, MSB first, one byte
  function automatic logic [7:0] crc8(input logic [7:0] crc_in, input logic [7:0] data);
    logic [7:0] c;
    c = crc_in ^ data;
    for (int i = 0; i < 8; i++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// File: rtl/htfd_front.sv
module htfd_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             byte_valid,
  output logic             byte_stall,
  input  logic [7:0]       rx_byte,
  input  logic             frame_start,
  input  logic             queue_full,
  output logic             push,
  output htfd_pkg::job_t   push_job
);

  htfd_pkg::pos_t byte_position, byte_position_next;
  htfd_pkg::pos_t pos;
  logic [7:0]     crc_accumulator, crc_accumulator_next;
  logic [15:0]    word_holder, word_holder_next;
  logic [15:0]    temp_raw_word, temp_raw_word_next;
  logic           temp_crc_good, temp_crc_good_next;
  logic           accept;

  assign byte_stall = queue_full;
  assign accept     = byte_valid && !byte_stall;
  assign pos        = frame_start ? htfd_pkg::POS_T_HI : byte_position;

  // position sequencing; an out-of-range position acts as the first byte
  always_comb begin
    unique case (pos)
      htfd_pkg::POS_T_HI:  byte_position_next = htfd_pkg::POS_T_LO;
      htfd_pkg::POS_T_LO:  byte_position_next = htfd_pkg::POS_T_CRC;
      htfd_pkg::POS_T_CRC: byte_position_next = htfd_pkg::POS_H_HI;
      htfd_pkg::POS_H_HI:  byte_position_next = htfd_pkg::POS_H_LO;
      htfd_pkg::POS_H_LO:  byte_position_next = htfd_pkg::POS_H_CRC;
      htfd_pkg::POS_H_CRC: byte_position_next = htfd_pkg::POS_T_HI;
      default:             byte_position_next = htfd_pkg::POS_T_LO;
    endcase
  end

  // datapath and job output
  always_comb begin
    crc_accumulator_next = crc_accumulator;
    word_holder_next     = word_holder;
    temp_raw_word_next   = temp_raw_word;
    temp_crc_good_next   = temp_crc_good;
    push                 = 1'b0;
    push_job.temp_raw    = temp_raw_word;
    push_job.hum_raw     = word_holder;
    push_job.temp_bad    = !temp_crc_good;
    push_job.hum_bad     = (crc_accumulator != rx_byte);
    unique case (pos)
      htfd_pkg::POS_T_HI, htfd_pkg::POS_H_HI: begin
        crc_accumulator_next = htfd_pkg::crc8(htfd_pkg::CRC_INIT, rx_byte);
        word_holder_next     = {rx_byte, 8'h00};
      end
      htfd_pkg::POS_T_LO, htfd_pkg::POS_H_LO: begin
        crc_accumulator_next = htfd_pkg::crc8(crc_accumulator, rx_byte);
        word_holder_next     = {word_holder[15:8], rx_byte};
      end
      htfd_pkg::POS_T_CRC: begin
        temp_crc_good_next   = (crc_accumulator == rx_byte);
        temp_raw_word_next   = word_holder;
        crc_accumulator_next = htfd_pkg::CRC_INIT;
      end
      htfd_pkg::POS_H_CRC: begin
        crc_accumulator_next = htfd_pkg::CRC_INIT;
        push                 = accept;
      end
      default: begin
        crc_accumulator_next = htfd_pkg::crc8(htfd_pkg::CRC_INIT, rx_byte);
        word_holder_next     = {rx_byte, 8'h00};
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position   <= htfd_pkg::POS_T_HI;
      crc_accumulator <= htfd_pkg::CRC_INIT;
      word_holder     <= '0;
      temp_raw_word   <= '0;
      temp_crc_good   <= 1'b0;
    end else if (accept) begin
      byte_position   <= byte_position_next;
      crc_accumulator <= crc_accumulator_next;
      word_holder     <= word_holder_next;
      temp_raw_word   <= temp_raw_word_next;
      temp_crc_good   <= temp_crc_good_next;
    end
  end

endmodule

// File: rtl/htfd_queue.sv
module htfd_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  htfd_pkg::job_t push_job,
  output logic           full,
  input  logic           pop,
  output htfd_pkg::job_t pop_job,
  output logic           not_empty
);

  htfd_pkg::job_t                 slots [htfd_pkg::QUEUE_DEPTH];
  logic [htfd_pkg::QUEUE_AW-1:0]  wr_ptr;
  logic [htfd_pkg::QUEUE_AW-1:0]  rd_ptr;
  logic [htfd_pkg::QUEUE_CW-1:0]  count;

  assign full      = (count == htfd_pkg::QUEUE_CW'(htfd_pkg::QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign pop_job   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  // depth is a power of two, pointers wrap naturally
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// File: rtl/htfd_back.sv
module htfd_back (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               job_ready,
  input  htfd_pkg::job_t                     job,
  output logic                               pop,
  output logic                               result_valid,
  input  logic                               result_stall,
  output logic signed [htfd_pkg::TEMP_W-1:0] temp_centi,
  output logic [htfd_pkg::HUM_W-1:0]         humidity_centi,
  output logic [1:0]                         frame_status,
  output logic                               reading_valid
);

  logic                         s1_valid;
  logic [htfd_pkg::TPROD_W-1:0] tprod;
  logic [htfd_pkg::HPROD_W-1:0] hprod;
  logic [1:0]                   s1_status;

  logic out_free, s1_free, s1_adv;

  logic [htfd_pkg::TPROD_W:0]   tsum;
  logic [htfd_pkg::HPROD_W:0]   hsum;
  logic [htfd_pkg::TQ_W-1:0]    tq;
  logic [htfd_pkg::HQ_W-1:0]    hq;
  logic signed [htfd_pkg::TQ_W:0] tval;
  logic [htfd_pkg::HUM_W-1:0]   hsat;

  assign out_free = !result_valid || !result_stall;
  assign s1_adv   = s1_valid && out_free;
  assign s1_free  = !s1_valid || s1_adv;
  assign pop      = job_ready && s1_free;

  // x / 65535 = (x + (x >> 16) + 1) >> 16 for the quotient ranges here
  always_comb begin
    tsum = {1'b0, tprod} + (htfd_pkg::TPROD_W+1)'(tprod >> 16) + 1'b1;
    hsum = {1'b0, hprod} + (htfd_pkg::HPROD_W+1)'(hprod >> 16) + 1'b1;
    tq   = tsum[16 +: htfd_pkg::TQ_W];
    hq   = hsum[16 +: htfd_pkg::HQ_W];
    tval = $signed({1'b0, tq}) - (htfd_pkg::TQ_W+1)'(htfd_pkg::TEMP_OFFSET);
    if (hq > htfd_pkg::HQ_W'(htfd_pkg::HUM_MAX)) begin
      hsat = htfd_pkg::HUM_W'(htfd_pkg::HUM_MAX);
    end else begin
      hsat = hq[htfd_pkg::HUM_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (s1_free) begin
        s1_valid <= job_ready;
      end
      if (out_free) begin
        result_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      tprod <= htfd_pkg::TPROD_W'(job.temp_raw) * htfd_pkg::TPROD_W'(htfd_pkg::TEMP_SCALE);
      hprod <= htfd_pkg::HPROD_W'(job.hum_raw) * htfd_pkg::HPROD_W'(htfd_pkg::HUM_SCALE);
      s1_status[htfd_pkg::STATUS_TEMP_BAD] <= job.temp_bad;
      s1_status[htfd_pkg::STATUS_HUM_BAD]  <= job.hum_bad;
    end
    if (s1_adv) begin
      temp_centi     <= tval[htfd_pkg::TEMP_W-1:0];
      humidity_centi <= hsat;
      frame_status   <= s1_status;
      reading_valid  <= (s1_status == htfd_pkg::STATUS_OK);
    end
  end

endmodule

// File: rtl/humidity_temp_frame_decoder_unit.sv
// channel   direction  handshake                   payload
// byte      in         byte_valid / byte_stall     rx_byte[7:0], frame_start
// result    out        result_valid / result_stall temp_centi[14:0] (signed),
//                                                  humidity_centi[13:0],
//                                                  frame_status[1:0], reading_valid
//
// One byte per cycle while byte_stall is low; a frame's result follows its sixth
// byte through the job queue, the multiply stage, then divide-by-65535 and output register.
// The byte side stalls only while the two-entry job queue is full.
// Synchronous active-high reset clears position, CRC, the queue and result_valid; reading_valid is not reset.
// A result stall backs up the conversion stages, then the queue, then bytes.
module humidity_temp_frame_decoder_unit (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               byte_valid,
  output logic                               byte_stall,
  input  logic [7:0]                         rx_byte,
  input  logic                               frame_start,
  output logic                               result_valid,
  input  logic                               result_stall,
  output logic signed [htfd_pkg::TEMP_W-1:0] temp_centi,
  output logic [htfd_pkg::HUM_W-1:0]         humidity_centi,
  output logic [1:0]                         frame_status,
  output logic                               reading_valid
);

  // front: frame position, CRC check, word capture -> one job per frame
  // queue: decouples byte intake from the conversion pipeline
  // back:  scale multiplies, reciprocal divide, offset and clamp
  logic           push, pop, queue_full, queue_not_empty;
  htfd_pkg::job_t push_job, pop_job;

  htfd_front u_front (
    .clk         (clk),
    .rst         (rst),
    .byte_valid  (byte_valid),
    .byte_stall  (byte_stall),
    .rx_byte     (rx_byte),
    .frame_start (frame_start),
    .queue_full  (queue_full),
    .push        (push),
    .push_job    (push_job)
  );

  htfd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_job  (push_job),
    .full      (queue_full),
    .pop       (pop),
    .pop_job   (pop_job),
    .not_empty (queue_not_empty)
  );

  htfd_back u_back (
    .clk            (clk),
    .rst            (rst),
    .job_ready      (queue_not_empty),
    .job            (pop_job),
    .pop            (pop),
    .result_valid   (result_valid),
    .result_stall   (result_stall),
    .temp_centi     (temp_centi),
    .humidity_centi (humidity_centi),
    .frame_status   (frame_status),
    .reading_valid  (reading_valid)
  );

endmodule

// File: rtl/htfd_checker.sv
module htfd_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               byte_valid,
  input logic                               byte_stall,
  input logic [7:0]                         rx_byte,
  input logic                               frame_start,
  input logic                               result_valid,
  input logic                               result_stall,
  input logic signed [htfd_pkg::TEMP_W-1:0] temp_centi,
  input logic [htfd_pkg::HUM_W-1:0]         humidity_centi,
  input logic [1:0]                         frame_status,
  input logic                               reading_valid
);

  // no result can follow reset before the cleared s1 stage has filled
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !result_valid ##1 !result_valid)
    else $error("result right after reset");

  a_valid_flag: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (reading_valid == (frame_status == htfd_pkg::STATUS_OK)))
    else $error("reading_valid disagrees with frame_status");

  a_ranges: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (temp_centi >= -15'sd4500) && (temp_centi <= 15'sd13000) &&
                     (humidity_centi <= 14'd10000))
    else $error("converted value out of range");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(temp_centi) &&
      $stable(humidity_centi) && $stable(frame_status))
    else $error("stalled result changed");

endmodule

bind humidity_temp_frame_decoder_unit htfd_checker u_checker (.*);
